// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent checks clocked on clk and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("check failed");
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error("check failed");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEVER(lbl, cond)
`endif
`endif

// File: rtl/core/fft_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// FFT package
// Sizes, register indexes, butterfly steps, word type, twiddle table and saturation.
// ---------------------------------------------------------------------------
package fft_pkg;

  localparam int LOG_MAX_POINTS = 6;
  localparam int MAX_POINTS     = 1 << LOG_MAX_POINTS;
  localparam int ADDR_W         = LOG_MAX_POINTS;
  localparam int TW_W           = LOG_MAX_POINTS - 1;
  localparam int HALF_PTS       = MAX_POINTS / 2;
  localparam int QUARTER_PTS    = MAX_POINTS / 4;
  localparam int WORD_W         = 32;
  localparam int SAMPLE_W       = 16;
  localparam int COEF_W         = 16;
  localparam int LOG_W          = 3;
  localparam int CFG_IDX_W      = 2;

  localparam logic [CFG_IDX_W-1:0] REG_INVERSE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOG_SIZE = 2'd1;

  typedef enum logic [2:0] {
    BS_HOLD,
    BS_LOAD_B,
    BS_LOAD_U,
    BS_MUL_BI_WI,
    BS_MUL_BR_WI,
    BS_MUL_BI_WR,
    BS_SUM_I,
    BS_ROUND
  } bf_step_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] re;
    logic signed [WORD_W-1:0] im;
  } cplx_t;

  // cos(2*pi*k/64) in Q1.15, first quarter turn
  function automatic logic signed [COEF_W-1:0] cos_base(input logic [TW_W-1:0] k);
    logic signed [COEF_W-1:0] c;
    case (k)
      5'd0:    c = 16'sd32767;
      5'd1:    c = 16'sd32610;
      5'd2:    c = 16'sd32138;
      5'd3:    c = 16'sd31357;
      5'd4:    c = 16'sd30274;
      5'd5:    c = 16'sd28899;
      5'd6:    c = 16'sd27246;
      5'd7:    c = 16'sd25330;
      5'd8:    c = 16'sd23170;
      5'd9:    c = 16'sd20788;
      5'd10:   c = 16'sd18205;
      5'd11:   c = 16'sd15447;
      5'd12:   c = 16'sd12540;
      5'd13:   c = 16'sd9512;
      5'd14:   c = 16'sd6393;
      5'd15:   c = 16'sd3212;
      default: c = 16'sd0;
    endcase
    return c;
  endfunction

  function automatic logic signed [COEF_W-1:0] tw_cos(input logic [TW_W-1:0] k);
    logic [TW_W:0] m;
    m = (TW_W+1)'(HALF_PTS) - {1'b0, k};
    if ({1'b0, k} <= (TW_W+1)'(QUARTER_PTS)) return cos_base(k);
    return -cos_base(m[TW_W-1:0]);
  endfunction

  function automatic logic signed [COEF_W-1:0] tw_sin(input logic [TW_W-1:0] k);
    logic [TW_W-1:0] q;
    q = TW_W'(QUARTER_PTS);
    if ({1'b0, k} <= (TW_W+1)'(QUARTER_PTS)) return cos_base(q - k);
    return cos_base(k - q);
  endfunction

  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [WORD_W+1:0] x);
    if (x > (WORD_W+2)'(64'sd2147483647)) return 32'sh7FFFFFFF;
    if (x < -(WORD_W+2)'(64'sd2147483648)) return 32'sh80000000;
    return x[WORD_W-1:0];
  endfunction

endpackage

// File: rtl/core/radix2_complex_fft.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Radix-2 complex FFT
// In-place decimation-in-time FFT over a 64-entry word buffer with one shared
// butterfly unit, Q24.8 saturating datapath and optional inverse scaling.
// ---------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  sample   | sample_valid, sample_stall | sample_real, sample_imag
//  bin      | bin_valid, bin_stall       | bin_real, bin_imag, last_bin
//  config   | cfg_write                  | cfg_index, cfg_data
//
// Load: one sample per cycle into its bit-reversed slot, while no config write stalls it.
// Transform: each butterfly runs through the single multiplier in S_RQ, S_RP,
//   S_M0 to S_M4 and S_RND; the buffer's one write port takes S_WP and S_WQ.
// Unload: per bin S_ORD, S_OLD, S_OWAIT until bin_stall is low; after the last, load resumes.
// Reset starts in load with forward mode and 64 points; the buffer is not cleared.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module radix2_complex_fft (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [fft_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [fft_pkg::LOG_W-1:0]             cfg_data,
  input  logic                                  sample_valid,
  output logic                                  sample_stall,
  input  logic signed [fft_pkg::SAMPLE_W-1:0]   sample_real,
  input  logic signed [fft_pkg::SAMPLE_W-1:0]   sample_imag,
  output logic                                  bin_valid,
  input  logic                                  bin_stall,
  output logic signed [fft_pkg::WORD_W-1:0]     bin_real,
  output logic signed [fft_pkg::WORD_W-1:0]     bin_imag,
  output logic                                  last_bin
);

  localparam int AW = fft_pkg::ADDR_W;
  localparam int TW = fft_pkg::TW_W;
  localparam int LW = fft_pkg::LOG_W;
  localparam int WW = fft_pkg::WORD_W;

  typedef enum logic [3:0] {
    S_LOAD, S_RQ, S_RP, S_M0, S_M1, S_M2, S_M3, S_M4,
    S_RND, S_WP, S_WQ, S_ORD, S_OLD, S_OWAIT
  } state_t;

  state_t                       state;
  logic                         inverse_mode;
  logic [LW-1:0]                log_size;
  logic [AW-1:0]                load_count;
  logic [LW-1:0]                stage;
  logic [AW-1:0]                grp;
  logic [TW-1:0]                bf_j;
  logic [AW-1:0]                out_idx;
  logic signed [fft_pkg::COEF_W-1:0] tw_re;
  logic signed [fft_pkg::COEF_W-1:0] tw_im;
  fft_pkg::cplx_t               mem [fft_pkg::MAX_POINTS];
  fft_pkg::cplx_t               rd_word;

  logic [LW-1:0]                eff_log;
  logic [AW:0]                  n_pts;
  logic [AW-1:0]                n_m1;
  logic [AW:0]                  len;
  logic [AW-1:0]                half;
  logic [AW-1:0]                p_addr;
  logic [AW-1:0]                q_addr;
  logic [TW-1:0]                tw_k;
  logic [AW-1:0]                rev_count;
  logic [AW-1:0]                load_slot;
  logic [AW-1:0]                rd_addr;
  logic                         mem_we;
  logic [AW-1:0]                mem_addr;
  fft_pkg::cplx_t               mem_wdata;
  fft_pkg::cplx_t               sample_word;
  fft_pkg::cplx_t               sum_word;
  fft_pkg::cplx_t               dif_word;
  fft_pkg::bf_step_t            step;
  logic signed [WW:0]           rnd;
  logic signed [WW:0]           scl_re;
  logic signed [WW:0]           scl_im;

  always_comb begin
    if (log_size == '0) eff_log = LW'(1);
    else if (log_size > LW'(fft_pkg::LOG_MAX_POINTS)) eff_log = LW'(fft_pkg::LOG_MAX_POINTS);
    else eff_log = log_size;
  end

  assign n_pts  = (AW+1)'(1) << eff_log;
  assign n_m1   = AW'(n_pts - (AW+1)'(1));
  assign len    = (AW+1)'(1) << stage;
  assign half   = AW'(len >> 1);
  assign p_addr = grp + AW'(bf_j);
  assign q_addr = p_addr + half;
  assign tw_k   = TW'(bf_j << (LW'(fft_pkg::LOG_MAX_POINTS) - stage));

  always_comb begin
    for (int i = 0; i < AW; i++) rev_count[i] = load_count[AW-1-i];
  end
  assign load_slot = rev_count >> (LW'(fft_pkg::LOG_MAX_POINTS) - eff_log);

  assign sample_word.re = {{(WW-fft_pkg::SAMPLE_W-8){sample_real[fft_pkg::SAMPLE_W-1]}},
                           sample_real, 8'b0};
  assign sample_word.im = {{(WW-fft_pkg::SAMPLE_W-8){sample_imag[fft_pkg::SAMPLE_W-1]}},
                           sample_imag, 8'b0};

  always_comb begin
    case (state)
      S_RQ:    rd_addr = q_addr;
      S_RP:    rd_addr = p_addr;
      default: rd_addr = out_idx;
    endcase
  end

  always_comb begin
    case (state)
      S_LOAD: begin
        mem_we = sample_valid && !sample_stall; mem_addr = load_slot; mem_wdata = sample_word;
      end
      S_WP: begin
        mem_we = 1'b1; mem_addr = p_addr; mem_wdata = sum_word;
      end
      S_WQ: begin
        mem_we = 1'b1; mem_addr = q_addr; mem_wdata = dif_word;
      end
      default: begin
        mem_we = 1'b0; mem_addr = p_addr; mem_wdata = sum_word;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rd_word <= mem[rd_addr];
  end

  always_comb begin
    case (state)
      S_RP:    step = fft_pkg::BS_LOAD_B;
      S_M0:    step = fft_pkg::BS_LOAD_U;
      S_M1:    step = fft_pkg::BS_MUL_BI_WI;
      S_M2:    step = fft_pkg::BS_MUL_BR_WI;
      S_M3:    step = fft_pkg::BS_MUL_BI_WR;
      S_M4:    step = fft_pkg::BS_SUM_I;
      S_RND:   step = fft_pkg::BS_ROUND;
      default: step = fft_pkg::BS_HOLD;
    endcase
  end

  fft_bfly u_bfly (
    .clk      (clk),
    .step     (step),
    .rd_word  (rd_word),
    .tw_re    (tw_re),
    .tw_im    (tw_im),
    .sum_word (sum_word),
    .dif_word (dif_word)
  );

  assign rnd    = (WW+1)'(1) << (eff_log - LW'(1));
  assign scl_re = ((WW+1)'(rd_word.re) + rnd) >>> eff_log;
  assign scl_im = ((WW+1)'(rd_word.im) + rnd) >>> eff_log;

  assign sample_stall = (state != S_LOAD) || cfg_write;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      inverse_mode <= 1'b0;
      log_size     <= LW'(fft_pkg::LOG_MAX_POINTS);
      load_count   <= '0;
      stage        <= LW'(1);
      grp          <= '0;
      bf_j         <= '0;
      out_idx      <= '0;
      bin_valid    <= 1'b0;
      last_bin     <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          fft_pkg::REG_INVERSE: begin
            inverse_mode <= cfg_data[0];
            load_count   <= '0;
          end
          fft_pkg::REG_LOG_SIZE: begin
            log_size   <= cfg_data;
            load_count <= '0;
          end
          default: ;
        endcase
      end
      case (state)
        S_LOAD: begin
          if (sample_valid && !sample_stall) begin
            if (load_count == n_m1) begin
              load_count <= '0;
              stage      <= LW'(1);
              grp        <= '0;
              bf_j       <= '0;
              state      <= S_RQ;
            end else begin
              load_count <= load_count + AW'(1);
            end
          end
        end
        S_RQ: begin
          tw_re <= fft_pkg::tw_cos(tw_k);
          tw_im <= inverse_mode ? -fft_pkg::tw_sin(tw_k) : fft_pkg::tw_sin(tw_k);
          state <= S_RP;
        end
        S_RP:  state <= S_M0;
        S_M0:  state <= S_M1;
        S_M1:  state <= S_M2;
        S_M2:  state <= S_M3;
        S_M3:  state <= S_M4;
        S_M4:  state <= S_RND;
        S_RND: state <= S_WP;
        S_WP:  state <= S_WQ;
        S_WQ: begin
          state <= S_RQ;
          if (AW'(bf_j) == half - AW'(1)) begin
            bf_j <= '0;
            if ((AW+1)'(grp) + len == n_pts) begin
              grp <= '0;
              if (stage == eff_log) begin
                out_idx <= '0;
                state   <= S_ORD;
              end else begin
                stage <= stage + LW'(1);
              end
            end else begin
              grp <= grp + AW'(len);
            end
          end else begin
            bf_j <= bf_j + TW'(1);
          end
        end
        S_ORD: state <= S_OLD;
        S_OLD: begin
          bin_real  <= inverse_mode ? scl_re[WW-1:0] : rd_word.re;
          bin_imag  <= inverse_mode ? scl_im[WW-1:0] : rd_word.im;
          last_bin  <= (out_idx == n_m1);
          bin_valid <= 1'b1;
          state     <= S_OWAIT;
        end
        S_OWAIT: begin
          if (!bin_stall) begin
            bin_valid <= 1'b0;
            if (last_bin) begin
              state <= S_LOAD;
            end else begin
              out_idx <= out_idx + AW'(1);
              state   <= S_ORD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  `ASSERT_NEVER(a_no_load_while_out, !sample_stall && bin_valid)
  `ASSERT_CLK(a_valid_in_wait, bin_valid |-> state == S_OWAIT)
  `ASSERT_CLK(a_last_ends_frame, bin_valid && !bin_stall && last_bin |=> state == S_LOAD)
  `ASSERT_CLK(a_count_in_range, state == S_LOAD |-> load_count <= n_m1 || $past(cfg_write))

endmodule

// File: rtl/core/fft_bfly.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// FFT butterfly unit
// One shared multiplier stepped over the four twiddle products, rounding and
// saturating sum and difference of a radix-2 butterfly.
// ---------------------------------------------------------------------------
module fft_bfly (
  input  logic                                 clk,
  input  fft_pkg::bf_step_t                    step,
  input  fft_pkg::cplx_t                       rd_word,
  input  logic signed [fft_pkg::COEF_W-1:0]    tw_re,
  input  logic signed [fft_pkg::COEF_W-1:0]    tw_im,
  output fft_pkg::cplx_t                       sum_word,
  output fft_pkg::cplx_t                       dif_word
);

  localparam int PROD_W = fft_pkg::WORD_W + fft_pkg::COEF_W;
  localparam int ACC_W  = PROD_W + 1;

  fft_pkg::cplx_t b;
  fft_pkg::cplx_t u;
  fft_pkg::cplx_t v;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_i;

  logic signed [fft_pkg::WORD_W-1:0] mul_a;
  logic signed [fft_pkg::COEF_W-1:0] mul_b;
  logic signed [PROD_W-1:0]          mul_p;
  logic signed [ACC_W-1:0]           rnd_r;
  logic signed [ACC_W-1:0]           rnd_i;

  always_comb begin
    case (step)
      fft_pkg::BS_MUL_BI_WI: begin mul_a = b.im; mul_b = tw_im; end
      fft_pkg::BS_MUL_BR_WI: begin mul_a = b.re; mul_b = tw_im; end
      fft_pkg::BS_MUL_BI_WR: begin mul_a = b.im; mul_b = tw_re; end
      default:               begin mul_a = b.re; mul_b = tw_re; end
    endcase
  end

  assign mul_p = mul_a * mul_b;
  assign rnd_r = (acc_r + ACC_W'(16384)) >>> 15;
  assign rnd_i = (acc_i + ACC_W'(16384)) >>> 15;

  always_ff @(posedge clk) begin
    case (step)
      fft_pkg::BS_LOAD_B: b <= rd_word;
      fft_pkg::BS_LOAD_U: begin
        u    <= rd_word;
        prod <= mul_p;
      end
      fft_pkg::BS_MUL_BI_WI: begin
        acc_r <= ACC_W'(prod);
        prod  <= mul_p;
      end
      fft_pkg::BS_MUL_BR_WI: begin
        acc_r <= acc_r - ACC_W'(prod);
        prod  <= mul_p;
      end
      fft_pkg::BS_MUL_BI_WR: begin
        acc_i <= ACC_W'(prod);
        prod  <= mul_p;
      end
      fft_pkg::BS_SUM_I: acc_i <= acc_i + ACC_W'(prod);
      fft_pkg::BS_ROUND: begin
        v.re <= fft_pkg::sat_word(rnd_r[fft_pkg::WORD_W+1:0]);
        v.im <= fft_pkg::sat_word(rnd_i[fft_pkg::WORD_W+1:0]);
      end
      default: ;
    endcase
  end

  assign sum_word.re = fft_pkg::sat_word((fft_pkg::WORD_W+2)'(u.re) + (fft_pkg::WORD_W+2)'(v.re));
  assign sum_word.im = fft_pkg::sat_word((fft_pkg::WORD_W+2)'(u.im) + (fft_pkg::WORD_W+2)'(v.im));
  assign dif_word.re = fft_pkg::sat_word((fft_pkg::WORD_W+2)'(u.re) - (fft_pkg::WORD_W+2)'(v.re));
  assign dif_word.im = fft_pkg::sat_word((fft_pkg::WORD_W+2)'(u.im) - (fft_pkg::WORD_W+2)'(v.im));

endmodule

// File: sim/radix2_complex_fft_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Radix-2 complex FFT testbench
// Streams sample words through the FFT under several sizes and both
// directions, with random gaps and stalls, and checks every bin against a
// fixed-point transform computed alongside.
// ---------------------------------------------------------------------------
module radix2_complex_fft_test;

  localparam logic [fft_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [fft_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int CYCLE_LIMIT = 600000;
  localparam longint unsigned TWO_PI_Q32 = 64'd26986075409;

  typedef struct {
    logic signed [fft_pkg::SAMPLE_W-1:0] re;
    logic signed [fft_pkg::SAMPLE_W-1:0] im;
  } sample_word_t;

  typedef struct {
    logic signed [fft_pkg::WORD_W-1:0] re;
    logic signed [fft_pkg::WORD_W-1:0] im;
    logic                              last;
  } bin_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [fft_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [fft_pkg::LOG_W-1:0] cfg_data = '0;
  logic sample_valid = 1'b0;
  logic sample_stall;
  logic signed [fft_pkg::SAMPLE_W-1:0] sample_real = '0;
  logic signed [fft_pkg::SAMPLE_W-1:0] sample_imag = '0;
  logic bin_valid;
  logic bin_stall = 1'b0;
  logic signed [fft_pkg::WORD_W-1:0] bin_real;
  logic signed [fft_pkg::WORD_W-1:0] bin_imag;
  logic last_bin;

  radix2_complex_fft DUT (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .sample_valid(sample_valid), .sample_stall(sample_stall),
    .sample_real(sample_real), .sample_imag(sample_imag),
    .bin_valid(bin_valid), .bin_stall(bin_stall),
    .bin_real(bin_real), .bin_imag(bin_imag), .last_bin(last_bin)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // transform state mirrored from the block
  longint rom_cos [fft_pkg::HALF_PTS];
  longint rom_sin [fft_pkg::HALF_PTS];
  longint buf_re [fft_pkg::MAX_POINTS];
  longint buf_im [fft_pkg::MAX_POINTS];
  int     fill_count = 0;
  bit     inverse = 1'b0;
  int     size_log = 6;

  sample_word_t samples_pending [$];
  bin_word_t    bins_due [$];
  int  errors = 0;
  int  cycles = 0;
  bit  gap_free = 1'b0;
  bit  stall_free = 1'b0;
  int  gap_left = 0;
  int  stall_left = 0;
  bit  took_sample = 1'b0;
  bit  took_bin = 1'b0;

  function automatic longint to_q15(longint v);
    longint mag, r;
    mag = v < 0 ? -v : v;
    r = (mag + (64'sd1 << 14)) >>> 15;
    if (r > 32767) r = 32767;
    return v < 0 ? -r : r;
  endfunction

  function automatic void build_twiddles();
    longint unsigned t, oct, r, rr, x, x2, ts, tc;
    longint ss, cc, cv, sv;
    for (int k = 0; k < fft_pkg::HALF_PTS; k++) begin
      t = (longint'(k) << (16 - fft_pkg::LOG_MAX_POINTS)) & 64'hFFFF;
      oct = (t >> 13) & 3;
      r = t & 64'h1FFF;
      rr = oct[0] ? 8192 - r : r;
      x = (rr * TWO_PI_Q32 + (64'd1 << 17)) >> 18;
      x2 = (x * x) >> 30;
      ts = x;
      tc = 64'd1 << 30;
      ss = longint'(x);
      cc = 64'sd1 << 30;
      for (longint unsigned i = 1; i <= 7; i++) begin
        ts = ((ts * x2) >> 30) / ((2 * i) * (2 * i + 1));
        tc = ((tc * x2) >> 30) / ((2 * i - 1) * (2 * i));
        if (i[0]) begin
          ss -= longint'(ts);
          cc -= longint'(tc);
        end else begin
          ss += longint'(ts);
          cc += longint'(tc);
        end
      end
      case (oct)
        0: begin cv = cc; sv = ss; end
        1: begin cv = ss; sv = cc; end
        2: begin cv = -ss; sv = cc; end
        default: begin cv = -cc; sv = ss; end
      endcase
      rom_cos[k] = to_q15(cv);
      rom_sin[k] = to_q15(sv);
    end
  endfunction

  function automatic longint sat_q24(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic int active_log();
    if (size_log < 1) return 1;
    if (size_log > fft_pkg::LOG_MAX_POINTS) return fft_pkg::LOG_MAX_POINTS;
    return size_log;
  endfunction

  function automatic void add_sample(sample_word_t w);
    samples_pending.insert(samples_pending.size(), w);
  endfunction

  function automatic void fft_accept(sample_word_t w);
    int lg, n, slot, len, half, k, p, q;
    longint wr, wi, br, bi, vr, vi, ur, ui, rnd;
    bin_word_t b;
    lg = active_log();
    n = 1 << lg;
    if (fill_count >= n) fill_count = 0;
    slot = 0;
    for (int i = 0; i < lg; i++)
      if (fill_count[i]) slot |= 1 << (lg - 1 - i);
    buf_re[slot] = longint'(w.re) * 256;
    buf_im[slot] = longint'(w.im) * 256;
    fill_count++;
    if (fill_count < n) return;
    fill_count = 0;
    for (int s = 1; s <= lg; s++) begin
      len = 1 << s;
      half = len >> 1;
      for (int i = 0; i < n; i += len)
        for (int j = 0; j < half; j++) begin
          k = (j << (fft_pkg::LOG_MAX_POINTS - s)) % fft_pkg::HALF_PTS;
          wr = rom_cos[k];
          wi = inverse ? -rom_sin[k] : rom_sin[k];
          p = i + j;
          q = p + half;
          br = buf_re[q];
          bi = buf_im[q];
          vr = sat_q24((br * wr - bi * wi + (64'sd1 << 14)) >>> 15);
          vi = sat_q24((br * wi + bi * wr + (64'sd1 << 14)) >>> 15);
          ur = buf_re[p];
          ui = buf_im[p];
          buf_re[p] = sat_q24(ur + vr);
          buf_im[p] = sat_q24(ui + vi);
          buf_re[q] = sat_q24(ur - vr);
          buf_im[q] = sat_q24(ui - vi);
        end
    end
    if (inverse) begin
      rnd = 64'sd1 << (lg - 1);
      for (int i = 0; i < n; i++) begin
        buf_re[i] = (buf_re[i] + rnd) >>> lg;
        buf_im[i] = (buf_im[i] + rnd) >>> lg;
      end
    end
    for (int i = 0; i < n; i++) begin
      b.re = buf_re[i][fft_pkg::WORD_W-1:0];
      b.im = buf_im[i][fft_pkg::WORD_W-1:0];
      b.last = (i == n - 1);
      bins_due.insert(bins_due.size(), b);
    end
  endfunction

  // input side: advance to the next word once the current one is taken
  always @(negedge clk) begin
    logic nv;
    sample_word_t w;
    nv = sample_valid;
    if (rst) begin
      nv = 1'b0;
    end else begin
      if (sample_valid && took_sample) begin
        nv = 1'b0;
        gap_left = gap_free ? 0 : $urandom_range(0, 14);
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (samples_pending.size() > 0) begin
          w = samples_pending.pop_front();
          sample_real <= w.re;
          sample_imag <= w.im;
          nv = 1'b1;
        end
      end
    end
    sample_valid <= nv;
  end

  // output side: hold stall for a drawn number of cycles per bin
  always @(negedge clk) begin
    if (rst) begin
      bin_stall <= 1'b0;
    end else begin
      if (took_bin) stall_left = stall_free ? 0 : $urandom_range(0, 14);
      if (stall_left > 0) begin
        bin_stall <= 1'b1;
        stall_left--;
      end else begin
        bin_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    bin_word_t e;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      took_sample <= !rst && sample_valid && !sample_stall;
      took_bin <= !rst && bin_valid && !bin_stall;
      if (!rst && sample_valid && !sample_stall)
        fft_accept('{re: sample_real, im: sample_imag});
      if (!rst && bin_valid && !bin_stall) begin
        if (bins_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected bin %0d %0d last %0b", $time,
                   bin_real, bin_imag, last_bin);
        end else begin
          e = bins_due.pop_front();
          if (bin_real !== e.re) begin
            errors++;
            $display("%0t: bin_real expected %0d actual %0d", $time, e.re, bin_real);
          end
          if (bin_imag !== e.im) begin
            errors++;
            $display("%0t: bin_imag expected %0d actual %0d", $time, e.im, bin_imag);
          end
          if (last_bin !== e.last) begin
            errors++;
            $display("%0t: last_bin expected %0b actual %0b", $time, e.last, last_bin);
          end
        end
      end
    end
  end

  task automatic write_reg(logic [fft_pkg::CFG_IDX_W-1:0] idx,
                           logic [fft_pkg::LOG_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == fft_pkg::REG_INVERSE) begin
      inverse = val[0];
      fill_count = 0;
    end else if (idx == fft_pkg::REG_LOG_SIZE) begin
      size_log = val;
      fill_count = 0;
    end
  endtask

  // hold until the block has been quiet for a stretch of cycles
  task automatic wait_idle();
    int quiet;
    quiet = 0;
    while (quiet < 30) begin
      @(negedge clk);
      if (samples_pending.size() > 0 || sample_valid || sample_stall ||
          bins_due.size() > 0 || took_sample)
        quiet = 0;
      else
        quiet++;
    end
  endtask

  function automatic sample_word_t draw_sample();
    sample_word_t w;
    case ($urandom_range(0, 5))
      0: begin
        w.re = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        w.im = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      end
      1: begin
        w.re = $signed(16'($urandom_range(0, 15))) - 8;
        w.im = $signed(16'($urandom_range(0, 15))) - 8;
      end
      default: begin
        w.re = 16'($urandom);
        w.im = 16'($urandom);
      end
    endcase
    return w;
  endfunction

  task automatic push_set(int count);
    for (int i = 0; i < count; i++) add_sample(draw_sample());
  endtask

  initial begin
    int sent, lg, sets, n, extra;
    build_twiddles();
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    write_reg(fft_pkg::REG_LOG_SIZE, 3'd1);
    add_sample('{re: 16'sh7FFF, im: 16'sh8000});
    add_sample('{re: 16'sh8000, im: 16'sh7FFF});
    wait_idle();
    write_reg(fft_pkg::REG_LOG_SIZE, 3'd2);
    for (int i = 0; i < 4; i++) add_sample('{re: 16'sh7FFF, im: 16'sh7FFF});
    wait_idle();
    write_reg(fft_pkg::REG_LOG_SIZE, 3'd0);
    add_sample('{re: 16'sh8000, im: 16'sh8000});
    add_sample('{re: 16'sd3, im: -16'sd5});
    wait_idle();
    write_reg(fft_pkg::REG_INVERSE, 3'd1);
    write_reg(REG_SPARE_A, 3'd7);
    write_reg(REG_SPARE_B, 3'd5);
    add_sample('{re: 16'sd1, im: -16'sd1});
    add_sample('{re: 16'sd0, im: 16'sd3});
    wait_idle();
    write_reg(fft_pkg::REG_LOG_SIZE, 3'd3);
    for (int i = 0; i < 8; i++) add_sample('{re: 16'sh8000, im: 16'sh7FFF});
    wait_idle();

    sent = 0;
    for (int ph = 0; sent < 250; ph++) begin
      if (ph == 0) lg = 6;
      else if (ph == 1) lg = 7;
      else if ($urandom_range(0, 3) == 0) lg = $urandom_range(0, 7);
      else lg = $urandom_range(1, 3);
      write_reg(fft_pkg::REG_LOG_SIZE, 3'(lg));
      write_reg(fft_pkg::REG_INVERSE, (ph == 0) ? 3'd1 : 3'($urandom_range(0, 1)));
      gap_free = ($urandom_range(0, 3) == 0);
      stall_free = ($urandom_range(0, 3) == 0);
      n = 1 << active_log();
      sets = (n >= 32) ? 1 : $urandom_range(1, 3);
      push_set(sets * n);
      sent += sets * n;
      // drop a partial load on the next register write
      if ($urandom_range(0, 3) == 0) begin
        extra = $urandom_range(1, n - 1);
        push_set(extra);
        sent += extra;
      end
      wait_idle();
    end

    wait_idle();
    repeat (100) @(negedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
